// ===== src/wmieu_pkg.sv =====
// ----------------------------------------------------------------------------
// wmieu_pkg
// Types, command codes, error codes and width-mask helpers of the integer execute unit.
// ----------------------------------------------------------------------------
package wmieu_pkg;

   localparam int NUM_REGS_DEFAULT = 64;
   localparam int XLEN = 64;

   localparam logic [4:0] CMD_MOV = 5'd0, CMD_ADD = 5'd1, CMD_SUB = 5'd2, CMD_MUL = 5'd3,
      CMD_UDIV = 5'd4, CMD_SDIV = 5'd5, CMD_UREM = 5'd6, CMD_SREM = 5'd7, CMD_AND = 5'd8,
      CMD_OR = 5'd9, CMD_XOR = 5'd10, CMD_SHL = 5'd11, CMD_LSHR = 5'd12, CMD_ASHR = 5'd13,
      CMD_EQ = 5'd14, CMD_NE = 5'd15, CMD_ULT = 5'd16, CMD_ULE = 5'd17, CMD_UGT = 5'd18,
      CMD_UGE = 5'd19, CMD_SLT = 5'd20, CMD_SLE = 5'd21, CMD_SGT = 5'd22, CMD_SGE = 5'd23,
      CMD_SELECT = 5'd24, CMD_ZEXT = 5'd25, CMD_SEXT = 5'd26, CMD_TRUNC = 5'd27;

   localparam logic [2:0] ERR_OK = 3'd0, ERR_DIV_ZERO = 3'd1, ERR_SHIFT = 3'd2,
      ERR_INDEX = 3'd3, ERR_COMMAND = 3'd4;

   typedef struct packed {
      logic [4:0]  command;
      logic [6:0]  width;
      logic [6:0]  src_width;
      logic [7:0]  dest_reg;
      logic [7:0]  a_reg;
      logic [7:0]  b_reg;
      logic [7:0]  c_reg;
      logic [63:0] imm_value;
      logic [2:0]  imm_select;
   } req_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic        written;
      logic [2:0]  error_code;
   } rsp_type;

   function automatic logic [63:0] wmask(input logic [6:0] w);
      logic [63:0] m;
      if (w >= 7'd64) m = '1;
      else m = (64'd1 << w[5:0]) - 64'd1;
      return m;
   endfunction

   function automatic logic [63:0] sext(input logic [63:0] v, input logic [6:0] from);
      logic [63:0] m;
      logic [63:0] x;
      m = wmask(from);
      x = v & m;
      if (from == 7'd0) x = '0;
      else if (from < 7'd64 && v[from[5:0] - 6'd1]) x = x | ~m;
      return x;
   endfunction

endpackage

// ===== src/wmieu_ram.sv =====
// ----------------------------------------------------------------------------
// wmieu_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module wmieu_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

// ===== src/width_masked_integer_execute_unit.sv =====
// ----------------------------------------------------------------------------
// width_masked_integer_execute_unit
// Integer instruction execution against a register file in RAM, with one
// shared add/subtract unit for add, subtract and the multiply and divide iterations.
// ----------------------------------------------------------------------------
//   channel  direction  handshake      payload
//   req      in         valid / stall  wmieu_pkg::req_type
//   rsp      out        valid / stall  wmieu_pkg::rsp_type
//
// One request at a time: req_stall is high in every state but idle. A bad
// command goes straight to the result, as do a divide by zero and a shift out
// of range once operands are read. Multiply and divide run 64 iterations on
// the shared adder; a shift by n runs n single-bit steps. After reset a
// clearing pass writes zero to each of NUM_REGS entries, one a cycle, with
// req_stall high. A result waits in its register while rsp_stall holds.
// ----------------------------------------------------------------------------
module width_masked_integer_execute_unit #(
   parameter int NUM_REGS = wmieu_pkg::NUM_REGS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  wmieu_pkg::req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output wmieu_pkg::rsp_type rsp_data
);
   localparam int AW = $clog2(NUM_REGS);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RDA, S_RDB, S_RDC, S_LAT, S_PREP, S_ITER, S_FIN, S_WRITE, S_OUT
   } state_type;

   state_type         state_ff;
   logic [AW:0]       clr_ff;
   wmieu_pkg::req_type q_ff;
   logic [1:0]        op_ff;
   logic [63:0]       a_ff, b_ff, c_ff;
   logic              bad_ff;
   logic [63:0]       acc_ff, rem_ff, sh_ff;
   logic [6:0]        cnt_ff;
   logic [63:0]       res_ff;
   logic              wr_ff;
   logic [2:0]        err_ff;
   logic              neg_ff;

   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   logic [63:0]       ram_wdata, ram_rdata;

   logic [6:0]        w, sw;
   logic [63:0]       m, am, bm, as, bs, ua, ub;
   logic [7:0]        cur_reg;
   logic              cur_imm;
   logic [4:0]        cmd;
   logic [64:0]       alu_sum;
   logic [63:0]       alu_x, alu_y;
   logic              alu_sub;
   logic              lt_s;

   assign w   = (q_ff.width > 7'd64) ? 7'd64 : q_ff.width;
   assign sw  = (q_ff.src_width > 7'd64) ? 7'd64 : q_ff.src_width;
   assign m   = wmieu_pkg::wmask(w);
   assign am  = a_ff & m;
   assign bm  = b_ff & m;
   assign as  = wmieu_pkg::sext(a_ff, w);
   assign bs  = wmieu_pkg::sext(bm, w);
   assign ua  = as[63] ? -as : as;
   assign ub  = bs[63] ? -bs : bs;
   assign cmd = q_ff.command;
   assign lt_s = $signed(as) < $signed(bs);

   always_comb begin
      cur_reg = q_ff.a_reg;
      cur_imm = q_ff.imm_select[0];
      case (op_ff)
         2'd1: begin cur_reg = q_ff.b_reg; cur_imm = q_ff.imm_select[1]; end
         2'd2: begin cur_reg = q_ff.c_reg; cur_imm = q_ff.imm_select[2]; end
         default: ;
      endcase
   end

   // shared adder: multiply accumulate, divide trial subtract, add/sub
   always_comb begin
      alu_x = acc_ff;
      alu_y = sh_ff;
      alu_sub = 1'b0;
      case (state_ff)
         S_ITER: begin
            if (cmd == wmieu_pkg::CMD_MUL) begin
               alu_x = acc_ff; alu_y = sh_ff;
            end else begin
               alu_x = {rem_ff[62:0], acc_ff[63]}; alu_y = sh_ff; alu_sub = 1'b1;
            end
         end
         default: begin
            alu_x = a_ff; alu_y = b_ff; alu_sub = (cmd == wmieu_pkg::CMD_SUB);
         end
      endcase
      alu_sum = {1'b0, alu_x} + {1'b0, alu_sub ? ~alu_y : alu_y} + {64'd0, alu_sub};
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_wdata = res_ff;
      ram_addr  = cur_reg[AW-1:0];
      if (state_ff == S_CLEAR) begin
         ram_we = 1'b1; ram_wdata = '0; ram_addr = clr_ff[AW-1:0];
      end else if (state_ff == S_WRITE) begin
         ram_we = wr_ff; ram_addr = q_ff.dest_reg[AW-1:0];
      end
   end

   wmieu_ram #(.WIDTH(64), .DEPTH(NUM_REGS)) u_ram (
      .clock(clock), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = '{result_value: res_ff, written: wr_ff, error_code: err_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == (AW+1)'(NUM_REGS - 1)) state_ff <= S_IDLE;
            end
            S_IDLE: begin
               if (req_valid) begin
                  q_ff <= req_data;
                  op_ff <= 2'd0;
                  bad_ff <= 1'b0;
                  a_ff <= '0; b_ff <= '0; c_ff <= '0;
                  if (req_data.command > wmieu_pkg::CMD_TRUNC) begin
                     res_ff <= '0; wr_ff <= 1'b0; err_ff <= wmieu_pkg::ERR_COMMAND;
                     state_ff <= S_OUT;
                  end else begin
                     state_ff <= S_RDA;
                  end
               end
            end
            S_RDA, S_RDB, S_RDC: state_ff <= S_LAT;
            S_LAT: begin
               logic [63:0] v;
               v = ram_rdata;
               if (cur_imm) v = q_ff.imm_value;
               else if ({1'b0, cur_reg} >= 9'(NUM_REGS)) begin
                  v = '0; bad_ff <= 1'b1;
               end
               case (op_ff)
                  2'd0: a_ff <= v;
                  2'd1: b_ff <= v;
                  default: c_ff <= v;
               endcase
               if (op_ff == 2'd0 && cmd >= wmieu_pkg::CMD_ADD && cmd <= wmieu_pkg::CMD_SELECT)
               begin
                  op_ff <= 2'd1; state_ff <= S_RDB;
               end else if (op_ff == 2'd1 && cmd == wmieu_pkg::CMD_SELECT) begin
                  op_ff <= 2'd2; state_ff <= S_RDC;
               end else begin
                  state_ff <= S_PREP;
               end
            end
            S_PREP: begin
               err_ff <= bad_ff ? wmieu_pkg::ERR_INDEX : wmieu_pkg::ERR_OK;
               wr_ff  <= ({1'b0, q_ff.dest_reg} < 9'(NUM_REGS));
               cnt_ff <= 7'd64;
               state_ff <= S_FIN;
               case (cmd)
                  wmieu_pkg::CMD_MOV, wmieu_pkg::CMD_TRUNC: res_ff <= am;
                  wmieu_pkg::CMD_ADD, wmieu_pkg::CMD_SUB: res_ff <= alu_sum[63:0] & m;
                  wmieu_pkg::CMD_MUL: begin
                     acc_ff <= '0; rem_ff <= b_ff; sh_ff <= a_ff; state_ff <= S_ITER;
                  end
                  wmieu_pkg::CMD_UDIV, wmieu_pkg::CMD_UREM,
                  wmieu_pkg::CMD_SDIV, wmieu_pkg::CMD_SREM: begin
                     if (bm == '0) begin
                        res_ff <= '0; wr_ff <= 1'b0; err_ff <= wmieu_pkg::ERR_DIV_ZERO;
                        state_ff <= S_OUT;
                     end else begin
                        logic sg;
                        sg = (cmd == wmieu_pkg::CMD_SDIV || cmd == wmieu_pkg::CMD_SREM);
                        acc_ff <= sg ? ua : am;
                        sh_ff  <= sg ? ub : bm;
                        rem_ff <= '0;
                        neg_ff <= (cmd == wmieu_pkg::CMD_SDIV) ? (as[63] ^ bs[63]) : as[63];
                        state_ff <= S_ITER;
                     end
                  end
                  wmieu_pkg::CMD_AND: res_ff <= a_ff & b_ff & m;
                  wmieu_pkg::CMD_OR:  res_ff <= (a_ff | b_ff) & m;
                  wmieu_pkg::CMD_XOR: res_ff <= (a_ff ^ b_ff) & m;
                  wmieu_pkg::CMD_SHL, wmieu_pkg::CMD_LSHR, wmieu_pkg::CMD_ASHR: begin
                     if (bm >= {57'd0, w}) begin
                        res_ff <= '0; wr_ff <= 1'b0; err_ff <= wmieu_pkg::ERR_SHIFT;
                        state_ff <= S_OUT;
                     end else begin
                        acc_ff <= (cmd == wmieu_pkg::CMD_SHL) ? a_ff :
                                  (cmd == wmieu_pkg::CMD_LSHR) ? am : as;
                        cnt_ff <= bm[6:0];
                        state_ff <= S_ITER;
                     end
                  end
                  wmieu_pkg::CMD_EQ:  res_ff <= {63'd0, am == bm};
                  wmieu_pkg::CMD_NE:  res_ff <= {63'd0, am != bm};
                  wmieu_pkg::CMD_ULT: res_ff <= {63'd0, am < bm};
                  wmieu_pkg::CMD_ULE: res_ff <= {63'd0, am <= bm};
                  wmieu_pkg::CMD_UGT: res_ff <= {63'd0, am > bm};
                  wmieu_pkg::CMD_UGE: res_ff <= {63'd0, am >= bm};
                  wmieu_pkg::CMD_SLT: res_ff <= {63'd0, lt_s};
                  wmieu_pkg::CMD_SLE: res_ff <= {63'd0, $signed(as) <= $signed(bs)};
                  wmieu_pkg::CMD_SGT: res_ff <= {63'd0, $signed(as) > $signed(bs)};
                  wmieu_pkg::CMD_SGE: res_ff <= {63'd0, !lt_s};
                  wmieu_pkg::CMD_SELECT: res_ff <= (a_ff[0] ? b_ff : c_ff) & m;
                  wmieu_pkg::CMD_ZEXT: res_ff <= a_ff & wmieu_pkg::wmask(sw) & m;
                  wmieu_pkg::CMD_SEXT: res_ff <= wmieu_pkg::sext(a_ff, sw) & m;
                  default: res_ff <= am;
               endcase
               if (cmd == wmieu_pkg::CMD_MUL || cmd == wmieu_pkg::CMD_SHL ||
                   cmd == wmieu_pkg::CMD_LSHR || cmd == wmieu_pkg::CMD_ASHR ||
                   cmd == wmieu_pkg::CMD_UDIV || cmd == wmieu_pkg::CMD_UREM ||
                   cmd == wmieu_pkg::CMD_SDIV || cmd == wmieu_pkg::CMD_SREM) begin
               end else begin
                  state_ff <= S_WRITE;
               end
            end
            S_ITER: begin
               if (cmd == wmieu_pkg::CMD_MUL) begin
                  if (rem_ff[0]) acc_ff <= alu_sum[63:0];
                  sh_ff  <= sh_ff << 1;
                  rem_ff <= rem_ff >> 1;
                  cnt_ff <= cnt_ff - 7'd1;
                  if (cnt_ff == 7'd1) state_ff <= S_FIN;
               end else if (cmd == wmieu_pkg::CMD_SHL || cmd == wmieu_pkg::CMD_LSHR ||
                            cmd == wmieu_pkg::CMD_ASHR) begin
                  if (cnt_ff == 7'd0) state_ff <= S_FIN;
                  else begin
                     cnt_ff <= cnt_ff - 7'd1;
                     case (cmd)
                        wmieu_pkg::CMD_SHL:  acc_ff <= acc_ff << 1;
                        wmieu_pkg::CMD_LSHR: acc_ff <= acc_ff >> 1;
                        default:             acc_ff <= {acc_ff[63], acc_ff[63:1]};
                     endcase
                  end
               end else begin
                  // restoring division, one quotient bit per cycle
                  logic [63:0] t;
                  t = {rem_ff[62:0], acc_ff[63]};
                  if (rem_ff[63] || alu_sum[64]) begin
                     rem_ff <= alu_sum[63:0];
                     acc_ff <= {acc_ff[62:0], 1'b1};
                  end else begin
                     rem_ff <= t;
                     acc_ff <= {acc_ff[62:0], 1'b0};
                  end
                  cnt_ff <= cnt_ff - 7'd1;
                  if (cnt_ff == 7'd1) state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               state_ff <= S_WRITE;
               case (cmd)
                  wmieu_pkg::CMD_UDIV: res_ff <= acc_ff & m;
                  wmieu_pkg::CMD_UREM: res_ff <= rem_ff & m;
                  wmieu_pkg::CMD_SDIV: res_ff <= (neg_ff ? -acc_ff : acc_ff) & m;
                  wmieu_pkg::CMD_SREM: res_ff <= (neg_ff ? -rem_ff : rem_ff) & m;
                  wmieu_pkg::CMD_MUL, wmieu_pkg::CMD_SHL, wmieu_pkg::CMD_LSHR,
                  wmieu_pkg::CMD_ASHR: res_ff <= acc_ff & m;
                  default: ;
               endcase
               if (!(cmd == wmieu_pkg::CMD_MUL || cmd == wmieu_pkg::CMD_SHL ||
                     cmd == wmieu_pkg::CMD_LSHR || cmd == wmieu_pkg::CMD_ASHR ||
                     (cmd >= wmieu_pkg::CMD_UDIV && cmd <= wmieu_pkg::CMD_SREM)))
                  res_ff <= res_ff;
            end
            S_WRITE: begin
               if (!wr_ff) err_ff <= wmieu_pkg::ERR_INDEX;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== test/wmieu_checker.sv =====
// ----------------------------------------------------------------------------
// wmieu_checker
// Watches both channels of the integer execute unit, keeps a shadow register
// file, predicts each result and compares it field by field.
// ----------------------------------------------------------------------------
module wmieu_checker #(
   parameter int NUM_REGS = wmieu_pkg::NUM_REGS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  wmieu_pkg::req_type req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  wmieu_pkg::rsp_type rsp_data,
   output int                 fail_count,
   output int                 pending_count,
   output int                 result_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [63:0]        shadow_regs [NUM_REGS];
   wmieu_pkg::rsp_type expected_results [$];

   function automatic logic [63:0] bit_mask(input int w);
      if (w >= 64) return '1;
      return (64'd1 << w) - 64'd1;
   endfunction

   function automatic logic [63:0] sign_fill(input logic [63:0] v, input int from);
      logic [63:0] m;
      logic [63:0] x;
      if (from == 0) return '0;
      if (from >= 64) return v;
      m = bit_mask(from);
      x = v & m;
      if (x[from - 1]) x = x | ~m;
      return x;
   endfunction

   function automatic logic [63:0] read_operand(input wmieu_pkg::req_type r, input int idx,
                                                input logic [7:0] rg, inout logic bad);
      if (r.imm_select[idx]) return r.imm_value;
      if (rg >= NUM_REGS) begin
         bad = 1'b1;
         return '0;
      end
      return shadow_regs[rg];
   endfunction

   function automatic wmieu_pkg::rsp_type execute_instruction(input wmieu_pkg::req_type r);
      wmieu_pkg::rsp_type o;
      int                 w;
      int                 sw;
      logic [63:0]        m, a, b, c, am, bm, as, bs, res, ua, ub, q;
      logic               bad;
      o = '0;
      bad = 1'b0;
      a = '0;
      b = '0;
      c = '0;
      res = '0;
      w = (r.width > 64) ? 64 : r.width;
      sw = (r.src_width > 64) ? 64 : r.src_width;
      m = bit_mask(w);
      if (r.command > wmieu_pkg::CMD_TRUNC) begin
         o.error_code = wmieu_pkg::ERR_COMMAND;
         return o;
      end
      a = read_operand(r, 0, r.a_reg, bad);
      if (r.command >= wmieu_pkg::CMD_ADD && r.command <= wmieu_pkg::CMD_SELECT)
         b = read_operand(r, 1, r.b_reg, bad);
      if (r.command == wmieu_pkg::CMD_SELECT) c = read_operand(r, 2, r.c_reg, bad);
      am = a & m;
      bm = b & m;
      as = sign_fill(a, w);
      bs = sign_fill(bm, w);
      case (r.command)
         wmieu_pkg::CMD_MOV, wmieu_pkg::CMD_TRUNC: res = am;
         wmieu_pkg::CMD_ADD: res = (a + b) & m;
         wmieu_pkg::CMD_SUB: res = (a - b) & m;
         wmieu_pkg::CMD_MUL: res = (a * b) & m;
         wmieu_pkg::CMD_UDIV, wmieu_pkg::CMD_UREM, wmieu_pkg::CMD_SDIV,
         wmieu_pkg::CMD_SREM: begin
            if (bm == 0) begin
               o.error_code = wmieu_pkg::ERR_DIV_ZERO;
               return o;
            end
            if (r.command == wmieu_pkg::CMD_UDIV) res = am / bm;
            else if (r.command == wmieu_pkg::CMD_UREM) res = am % bm;
            else begin
               ua = as[63] ? -as : as;
               ub = bs[63] ? -bs : bs;
               if (r.command == wmieu_pkg::CMD_SDIV) begin
                  q = ua / ub;
                  if (as[63] != bs[63]) q = -q;
               end else begin
                  q = ua % ub;
                  if (as[63]) q = -q;
               end
               res = q & m;
            end
         end
         wmieu_pkg::CMD_AND: res = a & b & m;
         wmieu_pkg::CMD_OR: res = (a | b) & m;
         wmieu_pkg::CMD_XOR: res = (a ^ b) & m;
         wmieu_pkg::CMD_SHL, wmieu_pkg::CMD_LSHR, wmieu_pkg::CMD_ASHR: begin
            if (bm >= w) begin
               o.error_code = wmieu_pkg::ERR_SHIFT;
               return o;
            end
            if (r.command == wmieu_pkg::CMD_SHL) res = (a << bm[5:0]) & m;
            else if (r.command == wmieu_pkg::CMD_LSHR) res = am >> bm[5:0];
            else begin
               q = $signed(as) >>> bm[5:0];
               res = q & m;
            end
         end
         wmieu_pkg::CMD_EQ: res = {63'd0, am == bm};
         wmieu_pkg::CMD_NE: res = {63'd0, am != bm};
         wmieu_pkg::CMD_ULT: res = {63'd0, am < bm};
         wmieu_pkg::CMD_ULE: res = {63'd0, am <= bm};
         wmieu_pkg::CMD_UGT: res = {63'd0, am > bm};
         wmieu_pkg::CMD_UGE: res = {63'd0, am >= bm};
         wmieu_pkg::CMD_SLT: res = {63'd0, $signed(as) < $signed(bs)};
         wmieu_pkg::CMD_SLE: res = {63'd0, $signed(as) <= $signed(bs)};
         wmieu_pkg::CMD_SGT: res = {63'd0, $signed(as) > $signed(bs)};
         wmieu_pkg::CMD_SGE: res = {63'd0, $signed(as) >= $signed(bs)};
         wmieu_pkg::CMD_SELECT: res = (a[0] ? b : c) & m;
         wmieu_pkg::CMD_ZEXT: res = a & bit_mask(sw) & m;
         wmieu_pkg::CMD_SEXT: res = sign_fill(a, sw) & m;
         default: res = am;
      endcase
      o.result_value = res;
      if (bad) o.error_code = wmieu_pkg::ERR_INDEX;
      if (r.dest_reg >= NUM_REGS) begin
         o.error_code = wmieu_pkg::ERR_INDEX;
         return o;
      end
      shadow_regs[r.dest_reg] = res;
      o.written = 1'b1;
      return o;
   endfunction

   always @(posedge clock) begin
      wmieu_pkg::rsp_type exp_rsp;
      if (reset) begin
         foreach (shadow_regs[i]) shadow_regs[i] = '0;
         expected_results.delete();
         fail_count <= 0;
         result_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_valid && !req_stall) expected_results.push_back(execute_instruction(req_data));
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transaction, actual %h", $time, rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               exp_rsp = expected_results.pop_front();
               if (exp_rsp.result_value !== rsp_data.result_value
                   || exp_rsp.written !== rsp_data.written
                   || exp_rsp.error_code !== rsp_data.error_code) begin
                  $display("%0t: mismatch expected val=%h wr=%b err=%0d actual val=%h wr=%b err=%0d",
                           $time, exp_rsp.result_value, exp_rsp.written, exp_rsp.error_code,
                           rsp_data.result_value, rsp_data.written, rsp_data.error_code);
                  fail_count <= fail_count + 1;
               end
            end
         end
         pending_count <= expected_results.size();
      end
   end
endmodule

// ===== test/tb_width_masked_integer_execute_unit.sv =====
// ----------------------------------------------------------------------------
// tb_width_masked_integer_execute_unit
// Drives directed and random instruction streams into the execute unit with
// random idling and back-pressure; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb_width_masked_integer_execute_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   wmieu_pkg::req_type req_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   wmieu_pkg::rsp_type rsp_data;
   int                 fail_count, pending_count, result_count;
   int                 idle_cycles = 0;
   logic               quiet_phase = 1'b0;
   logic               hold_phase = 1'b0;

   always #5 clock = ~clock;

   width_masked_integer_execute_unit dut (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   wmieu_checker u_checker (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count), .result_count(result_count)
   );

   function automatic logic [63:0] pick_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 64'h8000_0000_0000_0000;
         3: return 64'd1 << $urandom_range(0, 63);
         4: return 64'($urandom_range(0, 70));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic logic [7:0] pick_reg();
      if ($urandom_range(0, 19) == 0) return 8'($urandom_range(64, 255));
      if ($urandom_range(0, 3) == 0) return 8'($urandom_range(0, 3));
      return 8'($urandom_range(0, 63));
   endfunction

   function automatic logic [6:0] pick_width();
      case ($urandom_range(0, 9))
         0: return 7'd64;
         1: return 7'd1;
         2: return 7'($urandom_range(0, 127));
         3: return 7'($urandom_range(28, 36));
         default: return 7'($urandom_range(1, 64));
      endcase
   endfunction

   function automatic wmieu_pkg::req_type random_instruction();
      wmieu_pkg::req_type r;
      r.command = ($urandom_range(0, 39) == 0) ? 5'($urandom_range(28, 31))
                                              : 5'($urandom_range(0, 27));
      r.width = pick_width();
      r.src_width = pick_width();
      r.dest_reg = pick_reg();
      r.a_reg = pick_reg();
      r.b_reg = pick_reg();
      r.c_reg = pick_reg();
      r.imm_value = pick_value();
      r.imm_select = 3'($urandom_range(0, 7));
      return r;
   endfunction

   function automatic wmieu_pkg::req_type make_instruction(input logic [4:0] cmd,
                                                           input logic [6:0] w,
                                                           input logic [7:0] d,
                                                           input logic [7:0] a,
                                                           input logic [7:0] b,
                                                           input logic [63:0] imm,
                                                           input logic [2:0] sel);
      wmieu_pkg::req_type r;
      r = '{cmd, w, 7'd8, d, a, b, 8'd2, imm, sel};
      return r;
   endfunction

   task automatic send(input wmieu_pkg::req_type r);
      while (!quiet_phase && $urandom_range(0, 99) < 17) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (hold_phase) rsp_stall <= 1'b1;
      else if (quiet_phase) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 99) < 17);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d transactions outstanding", pending_count);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   initial begin
      int i;
      int k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // seed registers with extremes
      send(make_instruction(wmieu_pkg::CMD_MOV, 7'd64, 8'd0, 8'd0, 8'd0, '1, 3'b001));
      send(make_instruction(wmieu_pkg::CMD_MOV, 7'd64, 8'd1, 8'd0, 8'd0,
                            64'h8000_0000_0000_0000, 3'b001));
      send(make_instruction(wmieu_pkg::CMD_MOV, 7'd64, 8'd2, 8'd0, 8'd0, 64'd0, 3'b001));
      send(make_instruction(wmieu_pkg::CMD_MOV, 7'd64, 8'd63, 8'd0, 8'd0,
                            64'h5a5a_a5a5_0f0f_f0f0, 3'b001));
      send(make_instruction(wmieu_pkg::CMD_SDIV, 7'd64, 8'd3, 8'd1, 8'd0, 0, 3'b000));
      send(make_instruction(wmieu_pkg::CMD_SREM, 7'd64, 8'd4, 8'd1, 8'd0, 0, 3'b000));
      send(make_instruction(wmieu_pkg::CMD_SDIV, 7'd8, 8'd5, 8'd0, 8'd0, 64'h80, 3'b001));
      send(make_instruction(wmieu_pkg::CMD_UDIV, 7'd64, 8'd5, 8'd0, 8'd2, 0, 3'b000));
      send(make_instruction(wmieu_pkg::CMD_UREM, 7'd0, 8'd5, 8'd0, 8'd0, 0, 3'b000));
      send(make_instruction(wmieu_pkg::CMD_SHL, 7'd64, 8'd6, 8'd0, 8'd0, 64'd64, 3'b010));
      send(make_instruction(wmieu_pkg::CMD_ASHR, 7'd64, 8'd6, 8'd1, 8'd0, 64'd63, 3'b010));
      send(make_instruction(wmieu_pkg::CMD_LSHR, 7'd100, 8'd6, 8'd0, 8'd0, 64'd63, 3'b010));
      send(make_instruction(wmieu_pkg::CMD_ADD, 7'd64, 8'd7, 8'd200, 8'd0, 0, 3'b000));
      send(make_instruction(wmieu_pkg::CMD_ADD, 7'd64, 8'd255, 8'd0, 8'd0, 64'd1, 3'b010));
      send(make_instruction(wmieu_pkg::CMD_UDIV, 7'd64, 8'd7, 8'd0, 8'd100, 0, 3'b000));
      send(make_instruction(wmieu_pkg::CMD_MUL, 7'd64, 8'd8, 8'd0, 8'd1, 0, 3'b000));
      send(make_instruction(wmieu_pkg::CMD_SELECT, 7'd64, 8'd9, 8'd0, 8'd63, 0, 3'b000));
      send(make_instruction(wmieu_pkg::CMD_SEXT, 7'd64, 8'd10, 8'd0, 8'd0, 64'h80, 3'b001));
      send(make_instruction(wmieu_pkg::CMD_ZEXT, 7'd64, 8'd10, 8'd0, 8'd0, '1, 3'b001));
      send(make_instruction(wmieu_pkg::CMD_SLT, 7'd64, 8'd11, 8'd1, 8'd0, 0, 3'b000));
      send(make_instruction(wmieu_pkg::CMD_UGT, 7'd64, 8'd11, 8'd1, 8'd0, 0, 3'b000));
      send(make_instruction(5'd31, 7'd64, 8'd0, 8'd0, 8'd0, 0, 3'b000));
      send(make_instruction(wmieu_pkg::CMD_TRUNC, 7'd1, 8'd12, 8'd0, 8'd0, 0, 3'b000));
      for (k = wmieu_pkg::CMD_EQ; k <= wmieu_pkg::CMD_SGE; k++)
         send(make_instruction(5'(k), 7'd64, 8'd13, 8'd0, 8'd63, 0, 3'b000));
      drain();
      // long receiver hold while the sender keeps offering
      fork
         begin
            int n;
            hold_phase = 1'b1;
            for (n = 0; n < 400; n++) @(posedge clock);
            hold_phase = 1'b0;
         end
         begin
            for (i = 0; i < 30; i++) send(random_instruction());
            drain();
         end
      join
      for (i = 0; i < 1400; i++) begin
         quiet_phase = (i >= 600 && i < 800);
         send(random_instruction());
         if (i == 1000) drain();
      end
      quiet_phase = 1'b0;
      drain();
      repeat (200) @(posedge clock);
      $display("covered all commands, width extremes, bad indices, errors: %0d results",
               result_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ===== files.f =====
src/wmieu_pkg.sv
src/wmieu_ram.sv
src/width_masked_integer_execute_unit.sv
test/wmieu_checker.sv
test/tb_width_masked_integer_execute_unit.sv
